@@ hdl/nearest_palette_color_macros.svh @@
// Assertion macros shared by the checker of the nearest palette colour search.
`ifndef NEAREST_PALETTE_COLOR_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define NPC_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed: lbl");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define NPC_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed: lbl");

`endif

@@ hdl/npc_pkg.sv @@
// Package of types, constants and codes for the nearest palette colour search.
`default_nettype none
package npc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int FRACTION_BITS   = 8;

  localparam int PAL_LIMIT = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;
  localparam int ADDR_W    = $clog2(PALETTE_ENTRIES);
  localparam int N_W       = $clog2(PAL_LIMIT);
  localparam int IDX_W     = 8;
  localparam int IDX_EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam int COMP_W    = 6;
  localparam int COMP_MAX  = 63;
  localparam int Q_W       = 14;
  localparam int SCALED_W  = COMP_W + FRACTION_BITS;
  localparam int D_W       = (Q_W > SCALED_W) ? Q_W : SCALED_W;
  localparam int SQ_W      = 2 * D_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int DIST_W    = 30;
  localparam int CNT_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } npc_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_METRIC_MODE    = 1'b0,
    REG_ENTRIES_IN_USE = 1'b1
  } npc_reg_t;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } npc_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_DONE
  } npc_state_t;

  typedef struct packed {
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
  } npc_rgb_t;

  typedef struct packed {
    logic           valid;
    npc_sel_t       sel;
    logic           first;
    logic           last;
    logic           tail;
    logic [N_W-1:0] idx;
  } npc_step_t;

  typedef struct packed {
    logic             valid;
    logic             tail;
    logic [N_W-1:0]   idx;
    logic [SUM_W-1:0] sum;
  } npc_dist_t;

  function automatic logic [COMP_W-1:0] sat_comp(input logic [Q_W-1:0] v);
    logic [COMP_W-1:0] res;
    if (v > Q_W'(COMP_MAX)) begin
      res = COMP_W'(COMP_MAX);
    end else begin
      res = v[COMP_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hdl/npc_palette_mem.sv @@
// Palette memory: one write port and one registered read port.
`default_nettype none
module npc_palette_mem (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [npc_pkg::ADDR_W-1:0] wr_addr,
  input  wire npc_pkg::npc_rgb_t     wr_data,
  input  wire logic                  rd_en,
  input  wire logic [npc_pkg::ADDR_W-1:0] rd_addr,
  output npc_pkg::npc_rgb_t          rd_data
);
  import npc_pkg::*;

  npc_rgb_t mem [PALETTE_ENTRIES];
  npc_rgb_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ hdl/npc_dist_unit.sv @@
// Shared distance unit: one colour component per cycle, squared or not, accumulated.
`default_nettype none
module npc_dist_unit (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   metric_mode,
  input  wire npc_pkg::npc_step_t     step,
  input  wire npc_pkg::npc_rgb_t      pal,
  input  wire logic [npc_pkg::Q_W-1:0] q_red,
  input  wire logic [npc_pkg::Q_W-1:0] q_green,
  input  wire logic [npc_pkg::Q_W-1:0] q_blue,
  output npc_pkg::npc_dist_t          dsum
);
  import npc_pkg::*;

  logic [COMP_W-1:0] pal_c;
  logic [Q_W-1:0]    q_c;
  logic [D_W-1:0]    scaled;
  logic [D_W-1:0]    qx;
  logic [D_W-1:0]    diff;
  logic [SQ_W-1:0]   sq;
  logic [SUM_W-1:0]  term_nxt;
  logic [SUM_W-1:0]  acc_nxt;

  npc_step_t        s1_r;
  npc_step_t        s2_r;
  logic [D_W-1:0]   d1_r;
  logic [SUM_W-1:0] term_r;
  logic [SUM_W-1:0] acc_r;
  logic             out_valid_r;
  logic             out_tail_r;
  logic [N_W-1:0]   out_idx_r;

  always_comb begin
    unique case (step.sel)
      SEL_RED: begin
        pal_c = pal.r;
        q_c   = q_red;
      end
      SEL_GREEN: begin
        pal_c = pal.g;
        q_c   = q_green;
      end
      default: begin
        pal_c = pal.b;
        q_c   = q_blue;
      end
    endcase
    scaled = D_W'(pal_c) << FRACTION_BITS;
    qx     = D_W'(q_c);
    diff   = (scaled > qx) ? (scaled - qx) : (qx - scaled);
  end

  assign sq       = SQ_W'(d1_r) * SQ_W'(d1_r);
  assign term_nxt = metric_mode ? SUM_W'(sq) : SUM_W'(d1_r);
  assign acc_nxt  = s2_r.first ? term_r : (acc_r + term_r);

  always_ff @(posedge clk) begin
    s1_r.sel   <= step.sel;
    s1_r.first <= step.first;
    s1_r.last  <= step.last;
    s1_r.tail  <= step.tail;
    s1_r.idx   <= step.idx;
    d1_r       <= diff;
    s2_r.sel   <= s1_r.sel;
    s2_r.first <= s1_r.first;
    s2_r.last  <= s1_r.last;
    s2_r.tail  <= s1_r.tail;
    s2_r.idx   <= s1_r.idx;
    term_r     <= term_nxt;
    if (s2_r.valid) begin
      acc_r      <= acc_nxt;
      out_tail_r <= s2_r.tail;
      out_idx_r  <= s2_r.idx;
    end
    if (!rst_n) begin
      s1_r.valid  <= 1'b0;
      s2_r.valid  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_r.valid  <= step.valid;
      s2_r.valid  <= s1_r.valid;
      out_valid_r <= s2_r.valid && s2_r.last;
    end
  end

  assign dsum = '{valid: out_valid_r, tail: out_tail_r, idx: out_idx_r, sum: acc_r};

endmodule
`default_nettype wire

@@ hdl/npc_ctrl.sv @@
// Search sequencer: walks the palette, keeps the best entry and holds the result register.
`default_nettype none
module npc_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_op,
  input  wire logic [npc_pkg::Q_W-1:0]    in_red,
  input  wire logic [npc_pkg::Q_W-1:0]    in_green,
  input  wire logic [npc_pkg::Q_W-1:0]    in_blue,
  input  wire logic [npc_pkg::CNT_W-1:0]  entries_in_use,
  output logic                            rd_en,
  output logic [npc_pkg::ADDR_W-1:0]      rd_addr,
  output npc_pkg::npc_step_t              step,
  output logic [npc_pkg::Q_W-1:0]         q_red,
  output logic [npc_pkg::Q_W-1:0]         q_green,
  output logic [npc_pkg::Q_W-1:0]         q_blue,
  input  wire npc_pkg::npc_dist_t         dsum,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [npc_pkg::IDX_W-1:0]       out_index,
  output logic [npc_pkg::DIST_W-1:0]      out_distance
);
  import npc_pkg::*;

  npc_state_t       state_r, state_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  npc_sel_t         c_r, c_nxt;
  logic [N_W-1:0]   last_r, last_nxt;
  logic             have_r, have_nxt;
  logic [N_W-1:0]   best_idx_r, best_idx_nxt;
  logic [SUM_W-1:0] best_dist_r, best_dist_nxt;
  logic [Q_W-1:0]   qr_r, qg_r, qb_r;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  logic start;
  logic entry_done;
  logic search_end;
  logic out_free;
  logic take_best;

  assign start      = (state_r == ST_IDLE) && in_valid && (in_op == OP_QUERY);
  assign entry_done = (state_r == ST_SEARCH) && (c_r == SEL_BLUE);
  assign search_end = entry_done && (n_r == last_r);
  assign out_free   = !out_valid_r || out_ready;
  assign take_best  = dsum.valid && (!have_r || (dsum.sum < best_dist_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dsum.valid && dsum.tail) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    rd_en      = start || (entry_done && (n_r != last_r));
    rd_addr    = start ? '0 : (ADDR_W'(n_r) + ADDR_W'(1));
    step.valid = (state_r == ST_SEARCH);
    step.sel   = c_r;
    step.first = (c_r == SEL_RED);
    step.last  = (c_r == SEL_BLUE);
    step.tail  = (c_r == SEL_BLUE) && (n_r == last_r);
    step.idx   = n_r;
  end

  always_comb begin
    n_nxt         = n_r;
    c_nxt         = c_r;
    last_nxt      = last_r;
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (start) begin
      n_nxt    = '0;
      c_nxt    = SEL_RED;
      have_nxt = 1'b0;
      priority if (entries_in_use == '0) begin
        last_nxt = '0;
      end else if (entries_in_use > CNT_W'(PAL_LIMIT)) begin
        last_nxt = N_W'(PAL_LIMIT - 1);
      end else begin
        last_nxt = N_W'(entries_in_use - CNT_W'(1));
      end
    end
    if (state_r == ST_SEARCH) begin
      unique case (c_r)
        SEL_RED:   c_nxt = SEL_GREEN;
        SEL_GREEN: c_nxt = SEL_BLUE;
        default: begin
          c_nxt = SEL_RED;
          n_nxt = n_r + N_W'(1);
        end
      endcase
    end
    if (take_best) begin
      have_nxt      = 1'b1;
      best_idx_nxt  = dsum.idx;
      best_dist_nxt = dsum.sum;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      c_r         <= SEL_RED;
    end else begin
      state_r     <= state_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      c_r         <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    if (start) begin
      qr_r <= in_red;
      qg_r <= in_green;
      qb_r <= in_blue;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_idx_r  <= IDX_W'(best_idx_r);
      out_dist_r <= best_dist_r[DIST_W-1:0];
    end
  end

  assign q_red        = qr_r;
  assign q_green      = qg_r;
  assign q_blue       = qb_r;
  assign out_valid    = out_valid_r;
  assign out_index    = out_idx_r;
  assign out_distance = out_dist_r;

endmodule
`default_nettype wire

@@ hdl/nearest_palette_color.sv @@
// Top level of the nearest palette colour search.
//
// Input channel: a transaction with in_tuser low loads one palette entry (components
// above 63 saturate) and leaves in_tready high; in_tuser high is a query in 6.8 fixed
// point. Every entry in use must be loaded before the first query.
// A query reads the palette entries from the palette memory one after another, as the
// shared distance unit handles one colour component per cycle. With N entries searched
// (entries_in_use, zero taken as 1 and anything above 256 as 256), in_tready stays low
// until the result for all N entries has been moved into the output register, so the
// next transaction is taken only after that.
// Output channel: one transaction per query with the lowest-index closest entry and
// its distance (squared in Euclidean mode). The output register keeps a result while
// the receiver stalls; loads and a new query are still taken meanwhile, and a finished
// query waits for the register to free up.
// Configuration channel: cfg_ready is always high; register 0 selects the metric,
// register 1 the number of entries searched. Write it only while the block is idle.
// Reset (synchronous, rst_n low) empties the pipeline and the output register and
// restores the Euclidean metric with 256 entries; palette contents are not cleared.
`default_nettype none
module nearest_palette_color (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // entry_index[7:0], red[21:8], green[35:22], blue[49:36], zero padding
  input  wire logic [npc_pkg::IN_DATA_W-1:0] in_tdata,
  // op[0]
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // best_index[7:0], best_distance[37:8], zero padding
  output logic [npc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [npc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [npc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import npc_pkg::*;

  logic             metric_mode_r;
  logic [CNT_W-1:0] entries_r;

  logic [IDX_W-1:0] in_entry_index;
  logic [Q_W-1:0]   in_red;
  logic [Q_W-1:0]   in_green;
  logic [Q_W-1:0]   in_blue;
  logic [IDX_EXT_W-1:0] idx_ext;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  npc_rgb_t          wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  npc_rgb_t          rd_data;
  npc_step_t         step;
  npc_dist_t         dsum;
  logic [Q_W-1:0]    q_red, q_green, q_blue;
  logic [IDX_W-1:0]  out_index;
  logic [DIST_W-1:0] out_distance;

  assign in_entry_index = in_tdata[IDX_W-1:0];
  assign in_red         = in_tdata[IDX_W +: Q_W];
  assign in_green       = in_tdata[IDX_W + Q_W +: Q_W];
  assign in_blue        = in_tdata[IDX_W + 2*Q_W +: Q_W];

  assign idx_ext   = IDX_EXT_W'(in_entry_index);
  assign wr_addr   = idx_ext[ADDR_W-1:0];
  assign wr_en     = in_tvalid && in_tready && (in_tuser == OP_LOAD)
                     && (int'(in_entry_index) < PALETTE_ENTRIES);
  assign wr_data   = '{r: sat_comp(in_red), g: sat_comp(in_green), b: sat_comp(in_blue)};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_mode_r <= 1'b1;
      entries_r     <= CNT_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_METRIC_MODE:    metric_mode_r <= cfg_data[0];
        REG_ENTRIES_IN_USE: entries_r     <= cfg_data[CNT_W-1:0];
        default: begin
          metric_mode_r <= metric_mode_r;
        end
      endcase
    end
  end

  npc_palette_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  npc_dist_unit u_dist (
    .clk         (clk),
    .rst_n       (rst_n),
    .metric_mode (metric_mode_r),
    .step        (step),
    .pal         (rd_data),
    .q_red       (q_red),
    .q_green     (q_green),
    .q_blue      (q_blue),
    .dsum        (dsum)
  );

  npc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_op          (in_tuser),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .entries_in_use (entries_r),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .step           (step),
    .q_red          (q_red),
    .q_green        (q_green),
    .q_blue         (q_blue),
    .dsum           (dsum),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_index      (out_index),
    .out_distance   (out_distance)
  );

  assign out_tdata = OUT_DATA_W'({out_distance, out_index});

endmodule
`default_nettype wire

@@ hdl/npc_checker.sv @@
// Port-level checker for the nearest palette colour search, bound to the top level.
`default_nettype none
`include "nearest_palette_color_macros.svh"
module npc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [npc_pkg::IN_DATA_W-1:0]  in_tdata,
  input wire logic                           in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [npc_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [npc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [npc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import npc_pkg::*;

  logic query_acc;
  logic load_acc;
  logic unused_ok;

  assign query_acc = in_tvalid && in_tready && (in_tuser == OP_QUERY);
  assign load_acc  = in_tvalid && in_tready && (in_tuser == OP_LOAD);
  assign unused_ok = ^{in_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

  `NPC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `NPC_ASSERT_NXT(a_query_busy, query_acc, !in_tready)
  `NPC_ASSERT_NXT(a_load_no_stall, load_acc, in_tready)
  `NPC_ASSERT_IMP(a_out_pad_zero, out_tvalid, out_tdata[OUT_DATA_W-1:IDX_W+DIST_W] == '0)

endmodule

bind nearest_palette_color npc_checker u_npc_checker (.*);
`default_nettype wire

@@ tb/nearest_palette_color_tb.sv @@
// Self-checking testbench for the nearest palette colour search, with a built-in predictor.
module nearest_palette_color_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    npc_op_t     op;
    logic [7:0]  entry;
    logic [13:0] r;
    logic [13:0] g;
    logic [13:0] b;
  } colour_req_t;

  typedef struct packed {
    logic [7:0]  idx;
    logic [29:0] distance;
  } nearest_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  colour_req_t pending_reqs[$];
  nearest_t    expected_nearest[$];
  colour_req_t on_bus;

  npc_rgb_t    known_palette [256];
  bit          metric_is_sq = 1'b1;
  int          search_len = 256;

  npc_rgb_t    queued_palette [256];
  bit          queued_loaded [256];

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned failures = 0;
  int unsigned cycles = 0;

  nearest_palette_color dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [5:0] clip6(logic [13:0] v);
    return (v > 14'd63) ? 6'd63 : v[5:0];
  endfunction

  function automatic logic [13:0] load_comp();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 14'($urandom_range(0, 63));
    if (roll < 80) return 14'(21 * $urandom_range(0, 3));
    return 14'($urandom);
  endfunction

  function automatic logic [13:0] query_comp(logic [5:0] c);
    int unsigned roll;
    int          v;
    roll = $urandom_range(0, 99);
    v = int'(c) * 256 + int'($urandom_range(0, 64)) - 32;
    if (roll < 40) return 14'($urandom);
    if (roll < 80) return (v < 0) ? 14'd0 : 14'(v);
    return {c, 8'd0};
  endfunction

  task automatic push_load(logic [7:0] idx, logic [13:0] r, logic [13:0] g, logic [13:0] b);
    pending_reqs.push_back('{OP_LOAD, idx, r, g, b});
    queued_palette[idx] = '{clip6(r), clip6(g), clip6(b)};
    queued_loaded[idx] = 1'b1;
  endtask

  task automatic push_query(logic [13:0] r, logic [13:0] g, logic [13:0] b);
    pending_reqs.push_back('{OP_QUERY, 8'($urandom), r, g, b});
  endtask

  // Waits until every transaction has gone through and every answer has come back.
  task automatic settle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_nearest.size() != 0);
    repeat (3 * search_len + 10) @(posedge clk);
  endtask

  task automatic write_reg(npc_reg_t which, logic [8:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (which == REG_METRIC_MODE) begin
      metric_is_sq = value[0];
    end else begin
      search_len = (value == 0) ? 1 : (value > 256) ? 256 : int'(value);
    end
  endtask

  task automatic configure(bit metric, logic [8:0] count);
    settle();
    write_reg(REG_METRIC_MODE, {8'($urandom), metric});
    write_reg(REG_ENTRIES_IN_USE, count);
  endtask

  task automatic random_phase(int n, logic [8:0] count, bit metric);
    npc_rgb_t   pick;
    logic [7:0] idx;
    configure(metric, count);
    for (int i = 0; i < search_len; i++) begin
      if (!queued_loaded[i]) push_load(8'(i), load_comp(), load_comp(), load_comp());
    end
    repeat (n) begin
      if ($urandom_range(0, 99) < 35) begin
        idx = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, search_len - 1))
                                           : 8'($urandom_range(0, 255));
        push_load(idx, load_comp(), load_comp(), load_comp());
      end else begin
        pick = queued_palette[$urandom_range(0, search_len - 1)];
        push_query(query_comp(pick.r), query_comp(pick.g), query_comp(pick.b));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin : accept
        logic [13:0] dr, dg, db;
        logic [31:0] d, best_d;
        logic [7:0]  best_i;
        npc_rgb_t    e;
        if (on_bus.op == OP_LOAD) begin
          known_palette[on_bus.entry] = '{clip6(on_bus.r), clip6(on_bus.g), clip6(on_bus.b)};
        end else begin
          best_d = '0;
          best_i = '0;
          for (int n = 0; n < search_len; n++) begin
            e = known_palette[n];
            dr = ({e.r, 8'd0} > on_bus.r) ? {e.r, 8'd0} - on_bus.r : on_bus.r - {e.r, 8'd0};
            dg = ({e.g, 8'd0} > on_bus.g) ? {e.g, 8'd0} - on_bus.g : on_bus.g - {e.g, 8'd0};
            db = ({e.b, 8'd0} > on_bus.b) ? {e.b, 8'd0} - on_bus.b : on_bus.b - {e.b, 8'd0};
            if (metric_is_sq) d = dr * dr + dg * dg + db * db;
            else d = dr + dg + db;
            if (n == 0 || d < best_d) begin
              best_d = d;
              best_i = 8'(n);
            end
          end
          expected_nearest.push_back('{best_i, best_d[29:0]});
        end
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          on_bus = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'd0, on_bus.b, on_bus.g, on_bus.r, on_bus.entry};
          in_tuser  <= on_bus.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin : check
        nearest_t want;
        if (expected_nearest.size() == 0) begin
          $error("unexpected result transaction: best_index %0d, best_distance %0d",
                 out_tdata[7:0], out_tdata[37:8]);
          failures++;
        end else begin
          want = expected_nearest.pop_front();
          if (out_tdata[7:0] !== want.idx) begin
            $error("best_index: expected %0d, got %0d", want.idx, out_tdata[7:0]);
            failures++;
          end
          if (out_tdata[37:8] !== want.distance) begin
            $error("best_distance: expected %0d, got %0d", want.distance, out_tdata[37:8]);
            failures++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("nearest_palette_color_tb NOT OK");
      $finish;
    end
  end

  initial begin
    send_idle = 28;
    recv_idle = 75;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    push_load(8'd0, 14'd0, 14'd0, 14'd0);
    push_load(8'd1, 14'd16383, 14'd16383, 14'd16383);
    push_load(8'd2, 14'd64, 14'd63, 14'd1000);
    push_load(8'd3, 14'd21, 14'd42, 14'd10);
    for (int m = 1; m >= 0; m--) begin
      configure(1'(m), 9'd4);
      push_query(14'd0, 14'd0, 14'd0);
      push_query(14'd16383, 14'd16383, 14'd16383);
      push_query(14'd16128, 14'd16128, 14'd16128);
      push_query(14'd5376, 14'd10752, 14'd2560);
      push_query(14'd8064, 14'd8064, 14'd8064);
      push_query(14'd0, 14'd16383, 14'd0);
    end
    configure(1'b0, 9'd0);
    push_query(14'd16383, 14'd0, 14'd16383);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 28 : (mode == 1) ? 75 : 0;
      recv_idle = (mode == 0) ? 75 : (mode == 1) ? 28 : 0;
      random_phase(90, 9'($urandom_range(2, 8)), 1'($urandom_range(0, 1)));
      random_phase(50, (mode == 1) ? 9'd0 : 9'd1, 1'($urandom_range(0, 1)));
      random_phase(90, 9'($urandom_range(9, 40)), 1'($urandom_range(0, 1)));
      random_phase(25, (mode == 0) ? 9'd256 : (mode == 1) ? 9'd511
                                              : 9'($urandom_range(257, 510)), 1'(mode % 2));
      random_phase(90, 9'($urandom_range(41, 128)), 1'($urandom_range(0, 1)));
    end

    settle();
    if (failures == 0) begin
      $display("nearest_palette_color_tb OK");
    end else begin
      $display("nearest_palette_color_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/npc_pkg.sv
hdl/npc_palette_mem.sv
hdl/npc_dist_unit.sv
hdl/npc_ctrl.sv
hdl/nearest_palette_color.sv
hdl/npc_checker.sv
tb/nearest_palette_color_tb.sv
